// ===== hw/rtl/hmtq_pkg.sv =====
// ----------------------------------------------------------------------------
// hmtq_pkg: shared types and constants for the heightmap height query
// Field widths, derived datapath widths, status and opcode values, register
// indexes and reset values used by the interfaces and the RTL modules.
// ----------------------------------------------------------------------------
package hmtq_pkg;

   // Field widths
   localparam int COORD_W    = 32;
   localparam int VIDX_W     = 12;
   localparam int CELL_W     = 31;
   localparam int CNT_W      = 13;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam int DEF_MAX_VERTICES = 4096;

   // Datapath widths: vertex difference, edge product, plane normal,
   // plane numerator and divider remainder
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int NRM_W  = PROD_W + 1;
   localparam int NUM_W  = NRM_W + DIFF_W + 1;
   localparam int REM_W  = NRM_W + 1;

   // Opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_WRITE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DEGEN   = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TERRAIN_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERRAIN_DEPTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_DEPTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTS_PER_ROW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT     = 3'd5;

   // Register reset values
   localparam logic [CELL_W-1:0] RST_TERRAIN = 31'd4194304;
   localparam logic [CELL_W-1:0] RST_CELL    = 31'd65536;
   localparam logic [CNT_W-1:0]  RST_COUNT   = 13'd64;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic              operation;
      logic [VIDX_W-1:0] vertex_index;
      coord_type         pos_x;
      coord_type         pos_y;
      coord_type         pos_z;
      coord_type         query_x;
      coord_type         query_z;
   } req_type;

   typedef struct packed {
      coord_type           height;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Side data carried alongside the plane division
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                neg;
      coord_type           y0;
   } side_type;

endpackage

// ===== hw/rtl/hmtq_if.sv =====
// ----------------------------------------------------------------------------
// hmtq_if: request and response channels of the height query block
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hmtq_req_if import hmtq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [VIDX_W-1:0] vertex_index;
   coord_type         pos_x;
   coord_type         pos_y;
   coord_type         pos_z;
   coord_type         query_x;
   coord_type         query_z;

   modport source (
      output valid, operation, vertex_index, pos_x, pos_y, pos_z, query_x, query_z,
      input  ready
   );
   modport sink (
      input  valid, operation, vertex_index, pos_x, pos_y, pos_z, query_x, query_z,
      output ready
   );
endinterface

interface hmtq_rsp_if import hmtq_pkg::*; ();
   logic                valid;
   logic                ready;
   coord_type           height;
   logic [STATUS_W-1:0] status;

   modport source (output valid, height, status, input ready);
   modport sink (input valid, height, status, output ready);
endinterface

// ===== hw/rtl/hmtq_plane_div.sv =====
// ----------------------------------------------------------------------------
// hmtq_plane_div: pipelined unsigned divider for the plane solve
// Restoring division, one quotient bit per stage, side data carried along.
// ----------------------------------------------------------------------------
module hmtq_plane_div
   import hmtq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [NRM_W-1:0]   in_den,
   input  side_type           in_side,
   output logic               out_valid,
   output logic [NUM_W-1:0]   out_quot,
   output side_type           out_side
);

   localparam int PRQ_W = REM_W + NUM_W;

   // {remainder, dividend/quotient} per stage
   logic [PRQ_W-1:0] rq_ff   [NUM_W+1];
   logic [NRM_W-1:0] den_ff  [NUM_W+1];
   side_type         side_ff [NUM_W+1];
   logic [NUM_W:0]   v_ff;

   function automatic logic [PRQ_W-1:0] div_step(input logic [PRQ_W-1:0] rq,
                                                 input logic [NRM_W-1:0] dv);
      logic [PRQ_W-1:0] sh;
      sh = rq << 1;
      if (sh[PRQ_W-1:NUM_W] >= REM_W'(dv)) begin
         sh[PRQ_W-1:NUM_W] = sh[PRQ_W-1:NUM_W] - REM_W'(dv);
         sh[0] = 1'b1;
      end
      return sh;
   endfunction

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NUM_W-1:0], in_valid};
      end
   end

   // Stage data
   always_ff @(posedge clock) begin
      if (en) begin
         rq_ff[0]   <= {REM_W'(0), in_num};
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int k = 0; k < NUM_W; k++) begin
            rq_ff[k+1]   <= div_step(rq_ff[k], den_ff[k]);
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = v_ff[NUM_W];
   assign out_quot  = rq_ff[NUM_W][NUM_W-1:0];
   assign out_side  = side_ff[NUM_W];

   // A finished division leaves a remainder below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      v_ff[NUM_W] && den_ff[NUM_W] != '0 |->
         rq_ff[NUM_W][PRQ_W-1:NUM_W] < REM_W'(den_ff[NUM_W]))
      else $error("plane divider remainder not below divisor");

endmodule

// ===== hw/rtl/heightmap_triangle_height_query.sv =====
// ----------------------------------------------------------------------------
// heightmap_triangle_height_query: terrain height at a world x,z point
// Vertex store plus fully pipelined cell lookup, plane and height solve.
// ----------------------------------------------------------------------------
// One request enters per clock cycle while the output buffer is not full,
// write or query alike, and one response leaves per request, in order. A
// request passes the cell divider and the plane divider, each one bit per
// stage, on its way to the response; a stalled response channel freezes the
// whole pipeline, with a two-entry output buffer so requests are still taken
// while one response waits. The vertex store is written in request order at
// the same stage where queries read it, so a query always sees every earlier
// write. Entries never written read as garbage. Configuration may change
// only while no request is in flight.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_query
   import hmtq_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic                  clock,
   input  logic                  reset,
   hmtq_req_if.sink              req_ch,
   hmtq_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W  = $clog2(MAX_VERTICES);
   localparam int CRQ_W   = 2 * COORD_W;
   localparam int SHIFT_W = COORD_W + 1;
   localparam int BASE_W  = 2 * CNT_W + 2;
   localparam int WORD_W  = 3 * COORD_W;
   localparam int LO_W    = NRM_W - DIFF_W;
   localparam int PL_W    = LO_W + 1 + DIFF_W;
   localparam int PH_W    = 2 * DIFF_W;
   localparam int SUM_W   = NUM_W + 1;
   localparam int CDIV_N  = COORD_W;

   localparam coord_type SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // Configuration registers
   logic [CELL_W-1:0] cfg_tw_ff, cfg_td_ff, cfg_cw_ff, cfg_cd_ff;
   logic [CNT_W-1:0]  cfg_vpr_ff, cfg_rc_ff;

   // Pipeline enable
   logic en;

   // Input stage
   req_type s0_req_ff;
   logic    s0_v_ff;

   // Cell divider
   logic [SHIFT_W-1:0] sx_in, sz_in;
   logic               err_in;
   logic [CRQ_W-1:0]   cx_ff [CDIV_N+1];
   logic [CRQ_W-1:0]   cz_ff [CDIV_N+1];
   req_type            creq_ff [CDIV_N+1];
   logic               cerr_ff [CDIV_N+1];
   logic [CDIV_N:0]    cv_ff;

   // Cell bounds and triangle choice
   logic [COORD_W-1:0]  ix, iz;
   logic [CELL_W-1:0]   rx, rz;
   logic                b1_oob_in;
   req_type             b1_req_ff;
   logic                b1_oob_ff, b1_v_ff;
   logic [CNT_W-1:0]    b1_ix_ff;
   logic [2*CNT_W-1:0]  b1_izv_ff;
   logic [2*CELL_W-1:0] b1_px_ff, b1_pz_ff;

   // Vertex store
   logic [WORD_W-1:0]   mem_a [MAX_VERTICES];
   logic [WORD_W-1:0]   mem_b [MAX_VERTICES];
   logic [BASE_W-1:0]   base, top, idx_a, idx_b;
   logic                lower, vtx_wr;
   logic [STATUS_W-1:0] b3_st_in;
   logic [WORD_W-1:0]   rd_base_ff, rd_a_ff, rd_b_ff;
   logic [STATUS_W-1:0] b3_st_ff;
   coord_type           b3_qx_ff, b3_qz_ff;
   logic                b3_v_ff;

   // Edge vectors
   coord_type                x0, y0, z0, xa, ya, za, xb, yb, zb;
   logic signed [DIFF_W-1:0] b4_ax_ff, b4_ay_ff, b4_az_ff, b4_bx_ff, b4_by_ff, b4_bz_ff;
   logic signed [DIFF_W-1:0] b4_dqx_ff, b4_dqz_ff;
   coord_type                b4_y0_ff;
   logic [STATUS_W-1:0]      b4_st_ff;
   logic                     b4_v_ff;

   // Cross products
   logic signed [PROD_W-1:0] b5_p_in [6];
   logic signed [PROD_W-1:0] b5_p_ff [6];
   logic signed [DIFF_W-1:0] b5_dqx_ff, b5_dqz_ff;
   coord_type                b5_y0_ff;
   logic [STATUS_W-1:0]      b5_st_ff;
   logic                     b5_v_ff;

   // Normal
   logic signed [NRM_W-1:0]  b6_nx_ff, b6_ny_ff, b6_nz_ff;
   logic signed [DIFF_W-1:0] b6_dqx_ff, b6_dqz_ff;
   coord_type                b6_y0_ff;
   logic [STATUS_W-1:0]      b6_st_ff;
   logic                     b6_v_ff;

   // Partial products of the numerator
   logic signed [PL_W-1:0]  b7_plx_ff, b7_plz_ff;
   logic signed [PH_W-1:0]  b7_phx_ff, b7_phz_ff;
   logic signed [NRM_W-1:0] b7_ny_ff;
   coord_type               b7_y0_ff;
   logic [STATUS_W-1:0]     b7_st_in, b7_st_ff;
   logic                    b7_v_ff;

   // Numerator terms
   logic signed [NUM_W-1:0] b8_pnx_ff, b8_pnz_ff;
   logic signed [NRM_W-1:0] b8_ny_ff;
   coord_type               b8_y0_ff;
   logic [STATUS_W-1:0]     b8_st_ff;
   logic                    b8_v_ff;

   // Numerator
   logic signed [NUM_W-1:0] b9_num_ff;
   logic signed [NRM_W-1:0] b9_ny_ff;
   coord_type               b9_y0_ff;
   logic [STATUS_W-1:0]     b9_st_ff;
   logic                    b9_v_ff;

   // Division
   logic [NUM_W-1:0] div_num, div_quot;
   logic [NRM_W-1:0] div_den;
   side_type         div_side_in, div_side;
   logic             div_v;

   // Height
   logic signed [NUM_W-1:0] e1_qs_ff;
   coord_type               e1_y0_ff;
   logic [STATUS_W-1:0]     e1_st_ff;
   logic                    e1_v_ff;
   logic signed [SUM_W-1:0] e2_sum_ff;
   logic [STATUS_W-1:0]     e2_st_ff;
   logic                    e2_v_ff;
   logic [SUM_W-COORD_W:0]  sum_hi;
   coord_type               sat;
   rsp_type                 push_data;

   // Output buffer
   rsp_type    obuf_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] out_cnt_ff, out_cnt_in;
   logic       push, pop;

   function automatic logic [CRQ_W-1:0] cell_step(input logic [CRQ_W-1:0] rq,
                                                  input logic [CELL_W-1:0] dv);
      logic [CRQ_W-1:0] sh;
      sh = rq << 1;
      if (sh[CRQ_W-1:COORD_W] >= COORD_W'(dv)) begin
         sh[CRQ_W-1:COORD_W] = sh[CRQ_W-1:COORD_W] - COORD_W'(dv);
         sh[0] = 1'b1;
      end
      return sh;
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_tw_ff  <= RST_TERRAIN;
         cfg_td_ff  <= RST_TERRAIN;
         cfg_cw_ff  <= RST_CELL;
         cfg_cd_ff  <= RST_CELL;
         cfg_vpr_ff <= RST_COUNT;
         cfg_rc_ff  <= RST_COUNT;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TERRAIN_WIDTH: cfg_tw_ff  <= csr_wdata;
            CSR_TERRAIN_DEPTH: cfg_td_ff  <= csr_wdata;
            CSR_CELL_WIDTH:    cfg_cw_ff  <= csr_wdata;
            CSR_CELL_DEPTH:    cfg_cd_ff  <= csr_wdata;
            CSR_VERTS_PER_ROW: cfg_vpr_ff <= csr_wdata[CNT_W-1:0];
            CSR_ROW_COUNT:     cfg_rc_ff  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Whole pipeline advances unless the output buffer is full
   assign en           = (out_cnt_ff != 2'd2);
   assign req_ch.ready = en;

   // Shift by half the extent, reject negative points and zero spacing
   always_comb begin
      sx_in  = SHIFT_W'(s0_req_ff.query_x) + SHIFT_W'(cfg_tw_ff[CELL_W-1:1]);
      sz_in  = SHIFT_W'(s0_req_ff.query_z) + SHIFT_W'(cfg_td_ff[CELL_W-1:1]);
      err_in = sx_in[SHIFT_W-1] | sz_in[SHIFT_W-1] |
               (cfg_cw_ff == '0) | (cfg_cd_ff == '0);
   end

   // Cell index and remainder
   always_comb begin
      ix = cx_ff[CDIV_N][COORD_W-1:0];
      iz = cz_ff[CDIV_N][COORD_W-1:0];
      rx = cx_ff[CDIV_N][COORD_W+CELL_W-1:COORD_W];
      rz = cz_ff[CDIV_N][COORD_W+CELL_W-1:COORD_W];
      b1_oob_in = cerr_ff[CDIV_N] |
                  ((SHIFT_W'(ix) + SHIFT_W'(1)) >= SHIFT_W'(cfg_vpr_ff)) |
                  ((SHIFT_W'(iz) + SHIFT_W'(1)) >= SHIFT_W'(cfg_rc_ff));
   end

   // Store indexes of the three triangle corners
   always_comb begin
      base  = BASE_W'(b1_ix_ff) + BASE_W'(b1_izv_ff);
      top   = base + BASE_W'(1) + BASE_W'(cfg_vpr_ff);
      lower = (b1_px_ff > b1_pz_ff);
      idx_a = lower ? top : base + BASE_W'(cfg_vpr_ff);
      idx_b = lower ? base + BASE_W'(1) : top;
      vtx_wr = b1_v_ff && (b1_req_ff.operation == OP_WRITE) &&
               (32'(b1_req_ff.vertex_index) < 32'(MAX_VERTICES));
      if (b1_req_ff.operation == OP_WRITE) begin
         b3_st_in = ST_WRITE;
      end else if (b1_oob_ff || (32'(top) >= 32'(MAX_VERTICES))) begin
         b3_st_in = ST_OUTSIDE;
      end else begin
         b3_st_in = ST_OK;
      end
   end

   // Vertex store: written and read at the same stage keeps request order
   always_ff @(posedge clock) begin
      if (en) begin
         if (vtx_wr) begin
            mem_a[ADDR_W'(b1_req_ff.vertex_index)] <=
               {b1_req_ff.pos_x, b1_req_ff.pos_y, b1_req_ff.pos_z};
            mem_b[ADDR_W'(b1_req_ff.vertex_index)] <=
               {b1_req_ff.pos_x, b1_req_ff.pos_y, b1_req_ff.pos_z};
         end
         rd_base_ff <= mem_a[ADDR_W'(base)];
         rd_a_ff    <= mem_a[ADDR_W'(idx_a)];
         rd_b_ff    <= mem_b[ADDR_W'(idx_b)];
      end
   end

   // Unpack corner vertices
   always_comb begin
      {x0, y0, z0} = rd_base_ff;
      {xa, ya, za} = rd_a_ff;
      {xb, yb, zb} = rd_b_ff;
   end

   // Edge products
   always_comb begin
      b5_p_in[0] = b4_ay_ff * b4_bz_ff;
      b5_p_in[1] = b4_az_ff * b4_by_ff;
      b5_p_in[2] = b4_az_ff * b4_bx_ff;
      b5_p_in[3] = b4_ax_ff * b4_bz_ff;
      b5_p_in[4] = b4_ax_ff * b4_by_ff;
      b5_p_in[5] = b4_ay_ff * b4_bx_ff;
   end

   // Vertical plane check
   assign b7_st_in = ((b6_st_ff == ST_OK) && (b6_ny_ff == '0)) ? ST_DEGEN : b6_st_ff;

   // Magnitudes and sign for the divider
   always_comb begin
      div_num = b9_num_ff[NUM_W-1] ? NUM_W'(-b9_num_ff) : NUM_W'(b9_num_ff);
      div_den = b9_ny_ff[NRM_W-1] ? NRM_W'(-b9_ny_ff) : NRM_W'(b9_ny_ff);
      div_side_in.status = b9_st_ff;
      div_side_in.neg    = b9_num_ff[NUM_W-1] ^ b9_ny_ff[NRM_W-1];
      div_side_in.y0     = b9_y0_ff;
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         s0_req_ff.operation    <= req_ch.operation;
         s0_req_ff.vertex_index <= req_ch.vertex_index;
         s0_req_ff.pos_x        <= req_ch.pos_x;
         s0_req_ff.pos_y        <= req_ch.pos_y;
         s0_req_ff.pos_z        <= req_ch.pos_z;
         s0_req_ff.query_x      <= req_ch.query_x;
         s0_req_ff.query_z      <= req_ch.query_z;

         cx_ff[0]   <= {COORD_W'(0), sx_in[COORD_W-1:0]};
         cz_ff[0]   <= {COORD_W'(0), sz_in[COORD_W-1:0]};
         creq_ff[0] <= s0_req_ff;
         cerr_ff[0] <= err_in;
         for (int k = 0; k < CDIV_N; k++) begin
            cx_ff[k+1]   <= cell_step(cx_ff[k], cfg_cw_ff);
            cz_ff[k+1]   <= cell_step(cz_ff[k], cfg_cd_ff);
            creq_ff[k+1] <= creq_ff[k];
            cerr_ff[k+1] <= cerr_ff[k];
         end

         b1_req_ff <= creq_ff[CDIV_N];
         b1_oob_ff <= b1_oob_in;
         b1_ix_ff  <= ix[CNT_W-1:0];
         b1_izv_ff <= iz[CNT_W-1:0] * cfg_vpr_ff;
         b1_px_ff  <= rx * cfg_cd_ff;
         b1_pz_ff  <= rz * cfg_cw_ff;

         b3_st_ff <= b3_st_in;
         b3_qx_ff <= b1_req_ff.query_x;
         b3_qz_ff <= b1_req_ff.query_z;

         b4_ax_ff  <= DIFF_W'(xa) - DIFF_W'(x0);
         b4_ay_ff  <= DIFF_W'(ya) - DIFF_W'(y0);
         b4_az_ff  <= DIFF_W'(za) - DIFF_W'(z0);
         b4_bx_ff  <= DIFF_W'(xb) - DIFF_W'(x0);
         b4_by_ff  <= DIFF_W'(yb) - DIFF_W'(y0);
         b4_bz_ff  <= DIFF_W'(zb) - DIFF_W'(z0);
         b4_dqx_ff <= DIFF_W'(b3_qx_ff) - DIFF_W'(x0);
         b4_dqz_ff <= DIFF_W'(b3_qz_ff) - DIFF_W'(z0);
         b4_y0_ff  <= y0;
         b4_st_ff  <= b3_st_ff;

         for (int k = 0; k < 6; k++) begin
            b5_p_ff[k] <= b5_p_in[k];
         end
         b5_dqx_ff <= b4_dqx_ff;
         b5_dqz_ff <= b4_dqz_ff;
         b5_y0_ff  <= b4_y0_ff;
         b5_st_ff  <= b4_st_ff;

         b6_nx_ff  <= NRM_W'(b5_p_ff[0]) - NRM_W'(b5_p_ff[1]);
         b6_ny_ff  <= NRM_W'(b5_p_ff[2]) - NRM_W'(b5_p_ff[3]);
         b6_nz_ff  <= NRM_W'(b5_p_ff[4]) - NRM_W'(b5_p_ff[5]);
         b6_dqx_ff <= b5_dqx_ff;
         b6_dqz_ff <= b5_dqz_ff;
         b6_y0_ff  <= b5_y0_ff;
         b6_st_ff  <= b5_st_ff;

         // normal split into an unsigned low part and a signed high part
         b7_plx_ff <= $signed({1'b0, b6_nx_ff[LO_W-1:0]}) * b6_dqx_ff;
         b7_phx_ff <= $signed(b6_nx_ff[NRM_W-1:LO_W]) * b6_dqx_ff;
         b7_plz_ff <= $signed({1'b0, b6_nz_ff[LO_W-1:0]}) * b6_dqz_ff;
         b7_phz_ff <= $signed(b6_nz_ff[NRM_W-1:LO_W]) * b6_dqz_ff;
         b7_ny_ff  <= b6_ny_ff;
         b7_y0_ff  <= b6_y0_ff;
         b7_st_ff  <= b7_st_in;

         b8_pnx_ff <= (NUM_W'(b7_phx_ff) << LO_W) + NUM_W'(b7_plx_ff);
         b8_pnz_ff <= (NUM_W'(b7_phz_ff) << LO_W) + NUM_W'(b7_plz_ff);
         b8_ny_ff  <= b7_ny_ff;
         b8_y0_ff  <= b7_y0_ff;
         b8_st_ff  <= b7_st_ff;

         b9_num_ff <= NUM_W'(0) - b8_pnx_ff - b8_pnz_ff;
         b9_ny_ff  <= b8_ny_ff;
         b9_y0_ff  <= b8_y0_ff;
         b9_st_ff  <= b8_st_ff;

         e1_qs_ff <= div_side.neg ? NUM_W'(-div_quot) : NUM_W'(div_quot);
         e1_y0_ff <= div_side.y0;
         e1_st_ff <= div_side.status;

         e2_sum_ff <= SUM_W'(e1_qs_ff) + SUM_W'(e1_y0_ff);
         e2_st_ff  <= e1_st_ff;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         cv_ff   <= '0;
         b1_v_ff <= 1'b0;
         b3_v_ff <= 1'b0;
         b4_v_ff <= 1'b0;
         b5_v_ff <= 1'b0;
         b6_v_ff <= 1'b0;
         b7_v_ff <= 1'b0;
         b8_v_ff <= 1'b0;
         b9_v_ff <= 1'b0;
         e1_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_ch.valid;
         cv_ff   <= {cv_ff[CDIV_N-1:0], s0_v_ff};
         b1_v_ff <= cv_ff[CDIV_N];
         b3_v_ff <= b1_v_ff;
         b4_v_ff <= b3_v_ff;
         b5_v_ff <= b4_v_ff;
         b6_v_ff <= b5_v_ff;
         b7_v_ff <= b6_v_ff;
         b8_v_ff <= b7_v_ff;
         b9_v_ff <= b8_v_ff;
         e1_v_ff <= div_v;
         e2_v_ff <= e1_v_ff;
      end
   end

   hmtq_plane_div u_plane_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b9_v_ff),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_side   (div_side_in),
      .out_valid (div_v),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // Saturate to the coordinate range; errors and writes report zero height
   always_comb begin
      sum_hi = e2_sum_ff[SUM_W-1:COORD_W-1];
      if ((&sum_hi) || !(|sum_hi)) begin
         sat = e2_sum_ff[COORD_W-1:0];
      end else begin
         sat = e2_sum_ff[SUM_W-1] ? SAT_MIN : SAT_MAX;
      end
      push_data.height = (e2_st_ff == ST_OK) ? sat : '0;
      push_data.status = e2_st_ff;
   end

   // Two-entry output buffer
   assign push = en && e2_v_ff;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (push && !pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (pop && !push) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
      end else begin
         out_cnt_ff <= out_cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         obuf_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_ch.valid  = (out_cnt_ff != 2'd0);
   assign rsp_ch.height = obuf_ff[rd_ptr_ff].height;
   assign rsp_ch.status = obuf_ff[rd_ptr_ff].status;

   // Output buffer never holds more than two responses
   a_buf_count: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   // Error and write responses carry zero height
   a_err_height: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != ST_OK |-> rsp_ch.height == '0)
      else $error("nonzero height on a non-ok response");

   // A stall freezes the pipeline
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(b9_v_ff) && $stable(e2_v_ff) && $stable(cv_ff))
      else $error("pipeline moved while stalled");

endmodule
